// File: hw/rtl/bpe_pkg.sv
`timescale 1ns / 1ps
package bpe_pkg;

  localparam int MAX_POINTS = 16;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = 5;
  localparam int VAL_W      = 17;
  localparam int PWR_W      = 16;
  localparam int LIM_W      = 15;
  localparam int DVD_W      = 48;
  localparam int DSR_W      = 32;
  localparam int ARG_W      = 22;

  localparam logic [VAL_W-1:0] ONE_Q16      = 17'h10000;
  localparam logic [31:0]      ONE_Q31      = 32'h8000_0000;
  localparam logic [LIM_W-1:0] LINEAR_LIMIT = 15'd5;
  localparam logic [3:0]       SERIES_TERMS = 4'd13;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_EVAL  = 1'b1;

  localparam logic CFG_POINT_COUNT = 1'b0;
  localparam logic CFG_MAX_POWER   = 1'b1;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_NO_SEG    = 2'd1;
  localparam logic [1:0] STATUS_BAD_INDEX = 2'd2;

  typedef struct packed {
    logic [VAL_W-1:0]        x;
    logic [VAL_W-1:0]        y;
    logic signed [PWR_W-1:0] p;
  } bp_entry_t;

  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    bp_entry_t        wr_data;
  } tbl_req_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_END_RD,
    S_SCAN,
    S_SEG,
    S_T_WAIT,
    S_EQ_WAIT,
    S_ARG,
    S_EN_WAIT,
    S_R_WAIT,
    S_MAG,
    S_FIN,
    S_OUT
  } eval_state_e;

  typedef enum logic [2:0] {
    EX_IDLE,
    EX_SER_MUL,
    EX_SER_DIV,
    EX_SER_WAIT,
    EX_LOOP_MUL,
    EX_LOOP_RND,
    EX_DONE
  } exp_state_e;

  function automatic bp_entry_t bp_reset_entry(input logic [IDX_W-1:0] idx);
    bp_entry_t e;
    e = '0;
    if (idx == IDX_W'(0)) e.y = ONE_Q16;
    if (idx == IDX_W'(1)) e.x = ONE_Q16;
    return e;
  endfunction

endpackage

// File: hw/rtl/bpe_table.sv
`timescale 1ns / 1ps
module bpe_table import bpe_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  tbl_req_t  req_i,
  output bp_entry_t rd_data_o
);

  bp_entry_t             mem_q [MAX_POINTS];
  logic [MAX_POINTS-1:0] valid_q;
  bp_entry_t             rd_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
  end

  // unwritten entries read as their reset contents
  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rd_q <= valid_q[req_i.rd_addr] ? mem_q[req_i.rd_addr]
                                     : bp_reset_entry(req_i.rd_addr);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (req_i.wr_en) begin
      valid_q[req_i.wr_addr] <= 1'b1;
    end
  end

  assign rd_data_o = rd_q;

endmodule

// File: hw/rtl/bpe_div.sv
`timescale 1ns / 1ps
module bpe_div import bpe_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DSR_W-1:0] divisor_i,
  output logic             done_o,
  output logic [DVD_W-1:0] quot_o
);

  localparam int CW = $clog2(DVD_W);

  logic             busy_q, done_q;
  logic [CW-1:0]    cnt_q;
  logic [DVD_W-1:0] dvd_q, dvd_d;
  logic [DSR_W-1:0] rem_q, rem_d, dsr_q;
  logic [DSR_W:0]   trial;
  logic             ge;

  always_comb begin
    trial = {rem_q, dvd_q[DVD_W-1]};
    ge    = trial >= {1'b0, dsr_q};
    rem_d = ge ? DSR_W'(trial - {1'b0, dsr_q}) : trial[DSR_W-1:0];
    dvd_d = {dvd_q[DVD_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CW'(1);
        if (cnt_q == CW'(DVD_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // shift one quotient bit in per cycle
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dsr_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= dvd_d;
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = dvd_q;

endmodule

// File: hw/rtl/bpe_exp.sv
`timescale 1ns / 1ps
module bpe_exp import bpe_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [ARG_W-1:0] arg_i,
  output logic             done_o,
  output logic [31:0]      res_o
);

  exp_state_e        state_q, state_d;
  logic [ARG_W-1:0]  arg_q;
  logic              phase_q;
  logic [31:0]       term_q, e1_q, r_q;
  logic signed [33:0] sum_q, sum_nxt;
  logic [31:0]       sum_clamp;
  logic [3:0]        k_q;
  logic [5:0]        n_q;
  logic [63:0]       prod_q;
  logic [31:0]       mul_a, mul_b;
  logic [VAL_W-1:0]  frac;
  logic [31:0]       dvd_q, recip;
  logic [63:0]       rcp_prod_q;
  logic [31:0]       quo_est, rem_est, quot;
  logic [35:0]       quo_k;
  logic [63:0]       rnd;

  always_comb begin
    frac      = phase_q ? {1'b0, arg_q[15:0]} : ONE_Q16;
    mul_a     = (state_q == EX_SER_MUL) ? term_q : r_q;
    mul_b     = (state_q == EX_SER_MUL) ? {15'b0, frac} : e1_q;
    // floor(2^32 / k), saturated to 32'hFFFF_FFFF for k = 1; the estimate is low by at most one
    unique case (k_q)
      4'd1:    recip = 32'hFFFF_FFFF;
      4'd2:    recip = 32'h8000_0000;
      4'd3:    recip = 32'h5555_5555;
      4'd4:    recip = 32'h4000_0000;
      4'd5:    recip = 32'h3333_3333;
      4'd6:    recip = 32'h2AAA_AAAA;
      4'd7:    recip = 32'h2492_4924;
      4'd8:    recip = 32'h2000_0000;
      4'd9:    recip = 32'h1C71_C71C;
      4'd10:   recip = 32'h1999_9999;
      4'd11:   recip = 32'h1745_D174;
      4'd12:   recip = 32'h1555_5555;
      4'd13:   recip = 32'h13B1_3B13;
      default: recip = '0;
    endcase
    quo_est   = rcp_prod_q[63:32];
    quo_k     = 36'(quo_est) * 36'(k_q);
    rem_est   = 32'(36'(dvd_q) - quo_k);
    quot      = (rem_est >= 32'(k_q)) ? quo_est + 32'd1 : quo_est;
    sum_nxt   = k_q[0] ? sum_q - $signed({2'b0, quot})
                       : sum_q + $signed({2'b0, quot});
    if (sum_nxt < 0) sum_clamp = '0;
    else if (sum_nxt > $signed({2'b0, ONE_Q31})) sum_clamp = ONE_Q31;
    else sum_clamp = sum_nxt[31:0];
    rnd       = prod_q + 64'h4000_0000;
    done_o    = state_q == EX_DONE;
    state_d   = state_q;
    unique case (state_q)
      EX_IDLE:     if (start_i) state_d = EX_SER_MUL;
      EX_SER_MUL:  state_d = EX_SER_DIV;
      EX_SER_DIV:  state_d = EX_SER_WAIT;
      EX_SER_WAIT: begin
        if (k_q != SERIES_TERMS || !phase_q) state_d = EX_SER_MUL;
        else state_d = EX_LOOP_MUL;
      end
      EX_LOOP_MUL: state_d = (n_q == '0 || r_q == '0) ? EX_DONE : EX_LOOP_RND;
      EX_LOOP_RND: state_d = EX_LOOP_MUL;
      EX_DONE:     state_d = EX_IDLE;
      default:     state_d = EX_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= EX_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      EX_IDLE: begin
        arg_q   <= arg_i;
        phase_q <= 1'b0;
        term_q  <= ONE_Q31;
        sum_q   <= $signed({2'b0, ONE_Q31});
        k_q     <= 4'd1;
      end
      EX_SER_MUL, EX_LOOP_MUL: prod_q <= mul_a * mul_b;
      EX_SER_DIV: begin
        dvd_q      <= prod_q[47:16];
        rcp_prod_q <= prod_q[47:16] * recip;
      end
      EX_SER_WAIT: begin
        term_q <= quot;
        sum_q  <= sum_nxt;
        k_q    <= k_q + 4'd1;
        if (k_q == SERIES_TERMS) begin
          // first pass yields e^-1, second e^-frac
          term_q <= ONE_Q31;
          sum_q  <= $signed({2'b0, ONE_Q31});
          k_q    <= 4'd1;
          phase_q <= 1'b1;
          if (!phase_q) e1_q <= sum_clamp;
          else begin
            r_q <= sum_clamp;
            n_q <= arg_q[ARG_W-1:16];
          end
        end
      end
      EX_LOOP_RND: begin
        r_q <= rnd[62:31];
        n_q <= n_q - 6'd1;
      end
      default: ;
    endcase
  end

  assign res_o = r_q;

endmodule

// File: hw/rtl/breakpoint_exponential_curve_evaluator.sv
`timescale 1ns / 1ps
// The work for a request depends on its kind: a write only updates the table, an evaluation at
// 0 or 1.0 reads one end breakpoint, a search ending on a breakpoint scans the table, a straight
// segment takes one 48-step division, and a bent segment takes up to two exponentials (each two
// series passes plus scaling) and up to two divisions.
// One item at a time: input is taken again in the cycle after the result is loaded.
// Reset (async, active low) restores the breakpoint table and configuration registers to defaults.
module breakpoint_exponential_curve_evaluator import bpe_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // point_index, point_x, point_y, power_value, query_x, zero pad
  input  logic [71:0]          s_axis_tdata,
  // req_type
  input  logic                 s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // curve_y, status, zero pad
  output logic [23:0]          m_axis_tdata,
  input  logic                 cfg_we_i,
  input  logic                 cfg_idx_i,
  input  logic [LIM_W-1:0]     cfg_data_i
);

  eval_state_e state_q, state_d;

  logic [CNT_W-1:0]  pc_q, cnt;
  logic [LIM_W-1:0]  maxp_q;
  logic [VAL_W-1:0]  qx_q;
  logic [IDX_W-1:0]  idx_q;
  bp_entry_t         lo_q, hi_q, rd_data;
  tbl_req_t          tbl_req;
  logic [VAL_W-1:0]  t_q, ratio_q, res_y_q, out_y_q;
  logic [1:0]        res_st_q, out_st_q;
  logic [31:0]       eq_q, den;
  logic [33:0]       prod_q;
  logic              out_valid_q;

  logic [3:0]            in_idx;
  logic [VAL_W-1:0]      in_x, in_y, in_qx;
  logic signed [PWR_W-1:0] in_p, lim, p_clamp;

  logic [LIM_W-1:0]  q;
  logic [VAL_W-1:0]  s, w, dy, mag, lo_y, hi_y;
  logic [31:0]       qs;
  logic signed [32:0] num_s;
  logic [31:0]       num;
  logic              hit, nonlin;
  logic signed [19:0] res_s;
  logic [VAL_W-1:0]  res_c;

  logic              div_start, div_done, exp_start, exp_done;
  logic [DVD_W-1:0]  div_dvd, div_quot;
  logic [DSR_W-1:0]  div_dsr;
  logic [ARG_W-1:0]  exp_arg;
  logic [31:0]       exp_res;

  assign in_idx = s_axis_tdata[3:0];
  assign in_x   = s_axis_tdata[20:4];
  assign in_y   = s_axis_tdata[37:21];
  assign in_p   = s_axis_tdata[53:38];
  assign in_qx  = s_axis_tdata[70:54];

  bpe_table u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (tbl_req),
    .rd_data_o (rd_data)
  );

  bpe_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dsr),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  bpe_exp u_exp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (exp_start),
    .arg_i   (exp_arg),
    .done_o  (exp_done),
    .res_o   (exp_res)
  );

  always_comb begin
    if (pc_q < CNT_W'(2)) cnt = CNT_W'(2);
    else if (32'(pc_q) > MAX_POINTS) cnt = CNT_W'(MAX_POINTS);
    else cnt = pc_q;

    lim     = $signed({1'b0, maxp_q});
    if (in_p > lim) p_clamp = lim;
    else if (in_p < -lim) p_clamp = -lim;
    else p_clamp = in_p;

    q      = lo_q.p[PWR_W-1] ? LIM_W'(-lo_q.p) : lo_q.p[LIM_W-1:0];
    nonlin = q > LINEAR_LIMIT;
    s      = lo_q.p[PWR_W-1] ? t_q : VAL_W'(ONE_Q16 - t_q);
    qs     = 32'(q) * 32'(s) + 32'd512;
    w      = hi_q.x - lo_q.x;
    den    = ONE_Q31 - eq_q;
    num_s  = lo_q.p[PWR_W-1] ? $signed({1'b0, ONE_Q31}) - $signed({1'b0, exp_res})
                             : $signed({1'b0, exp_res}) - $signed({1'b0, eq_q});
    num    = (num_s < 0) ? '0 : num_s[31:0];
    hit    = qx_q >= lo_q.x && qx_q <= rd_data.x;

    lo_y   = (lo_q.y < hi_q.y) ? lo_q.y : hi_q.y;
    hi_y   = (lo_q.y < hi_q.y) ? hi_q.y : lo_q.y;
    dy     = (hi_q.y >= lo_q.y) ? VAL_W'(hi_q.y - lo_q.y) : VAL_W'(lo_q.y - hi_q.y);
    mag    = VAL_W'((prod_q + 34'd32768) >> 16);
    res_s  = (hi_q.y >= lo_q.y) ? $signed({3'b0, lo_q.y}) + $signed({3'b0, mag})
                                : $signed({3'b0, lo_q.y}) - $signed({3'b0, mag});
    if (res_s < $signed({3'b0, lo_y})) res_c = lo_y;
    else if (res_s > $signed({3'b0, hi_y})) res_c = hi_y;
    else res_c = res_s[VAL_W-1:0];

    div_start = 1'b0;
    div_dvd   = {15'b0, VAL_W'(qx_q - lo_q.x), 16'b0} + DVD_W'(w >> 1);
    div_dsr   = DSR_W'(w);
    exp_start = 1'b0;
    exp_arg   = {1'b0, q, 6'b0};

    tbl_req         = '0;
    tbl_req.wr_addr = in_idx[IDX_W-1:0];
    tbl_req.wr_data = '{x: in_x, y: in_y, p: p_clamp};
    tbl_req.rd_addr = idx_q + IDX_W'(1);

    s_axis_tready = state_q == S_IDLE;
    state_d       = state_q;

    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          if (s_axis_tuser == REQ_WRITE) begin
            tbl_req.wr_en = CNT_W'(in_idx) < cnt;
            state_d       = S_OUT;
          end else begin
            tbl_req.rd_en = 1'b1;
            if (in_qx == ONE_Q16) begin
              tbl_req.rd_addr = IDX_W'(cnt - CNT_W'(1));
              state_d         = S_END_RD;
            end else if (in_qx == '0) begin
              tbl_req.rd_addr = '0;
              state_d         = S_END_RD;
            end else begin
              tbl_req.rd_addr = '0;
              state_d         = S_SCAN;
            end
          end
        end
      end
      S_END_RD: state_d = S_OUT;
      S_SCAN: begin
        if (idx_q != '0 && hit) state_d = S_SEG;
        else if (CNT_W'(idx_q) == cnt - CNT_W'(1)) state_d = S_OUT;
        else tbl_req.rd_en = 1'b1;
      end
      S_SEG: begin
        if (lo_q.x == hi_q.x || qx_q == lo_q.x || qx_q == hi_q.x) state_d = S_OUT;
        else begin
          div_start = 1'b1;
          state_d   = S_T_WAIT;
        end
      end
      S_T_WAIT: begin
        if (div_done) begin
          if (nonlin) begin
            exp_start = 1'b1;
            state_d   = S_EQ_WAIT;
          end else state_d = S_MAG;
        end
      end
      S_EQ_WAIT: begin
        if (exp_done) state_d = (exp_res == ONE_Q31) ? S_MAG : S_ARG;
      end
      S_ARG: begin
        exp_start = 1'b1;
        exp_arg   = qs[31:10];
        state_d   = S_EN_WAIT;
      end
      S_EN_WAIT: begin
        if (exp_done) begin
          div_start = 1'b1;
          div_dvd   = {num, 16'b0} + DVD_W'(den >> 1);
          div_dsr   = den;
          state_d   = S_R_WAIT;
        end
      end
      S_R_WAIT: if (div_done) state_d = S_MAG;
      S_MAG:    state_d = S_FIN;
      S_FIN:    state_d = S_OUT;
      S_OUT:    if (!out_valid_q || m_axis_tready) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pc_q        <= CNT_W'(2);
      maxp_q      <= LIM_W'(10240);
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_POINT_COUNT: pc_q   <= cfg_data_i[CNT_W-1:0];
          CFG_MAX_POWER:   maxp_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (state_q == S_OUT && (!out_valid_q || m_axis_tready)) out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_OUT && (!out_valid_q || m_axis_tready)) begin
      out_y_q  <= res_y_q;
      out_st_q <= res_st_q;
    end
    unique case (state_q)
      S_IDLE: begin
        qx_q     <= in_qx;
        idx_q    <= '0;
        res_y_q  <= '0;
        res_st_q <= STATUS_OK;
        if (s_axis_tuser == REQ_WRITE && CNT_W'(in_idx) >= cnt) res_st_q <= STATUS_BAD_INDEX;
      end
      S_END_RD: res_y_q <= rd_data.y;
      S_SCAN: begin
        hi_q <= rd_data;
        if (!(idx_q != '0 && hit)) begin
          lo_q  <= rd_data;
          idx_q <= idx_q + IDX_W'(1);
          if (CNT_W'(idx_q) == cnt - CNT_W'(1)) res_st_q <= STATUS_NO_SEG;
        end
      end
      S_SEG: begin
        res_y_q <= (qx_q == lo_q.x && lo_q.x != hi_q.x) ? lo_q.y : hi_q.y;
      end
      S_T_WAIT: begin
        t_q     <= div_quot[VAL_W-1:0];
        ratio_q <= div_quot[VAL_W-1:0];
      end
      S_EQ_WAIT: eq_q <= exp_res;
      S_R_WAIT: begin
        ratio_q <= (div_quot > DVD_W'(ONE_Q16)) ? ONE_Q16 : div_quot[VAL_W-1:0];
      end
      S_MAG:   prod_q  <= 34'(ratio_q) * 34'(dy);
      S_FIN:   res_y_q <= res_c;
      default: ;
    endcase
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b0, out_st_q, out_y_q};

endmodule
